/* hw/rtl/lssc_pkg.sv */
// Shared types and constants for the load switch sense converter.
// Used by lssc_tables and load_switch_sense_converter_unit; depends on nothing.

package lssc_pkg;

   localparam int unsigned CHANNELS_DEF    = 32;
   localparam int unsigned SENSE_RATIO_DEF = 4700;
   localparam int unsigned SENSE_OHM_DEF   = 1000;

   localparam int CH_W       = 5;
   localparam int RAW_W      = 16;
   localparam int TBL_W      = 16;
   localparam int CUR_W      = 23;
   localparam int TEMP_W     = 9;
   localparam int UV_W       = 23;
   localparam int MV_W       = 13;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_W      = 23;
   localparam int CSR_IDX_W  = 2;

   // Full-scale microvolts is 4096000, which is 62 * 65535 + 32830.
   localparam longint unsigned UV_MAX       = 64'd4096000;
   localparam logic [UV_W-1:0] UV_WHOLE_MUL = 23'd62;
   localparam logic [31:0]     UV_FRAC_MUL  = 32'd32830;
   localparam logic [16:0]     ADC_FULL     = 17'd65535;

   localparam logic [TBL_W-1:0] SCALE_ONE = 16'd256;
   localparam logic [CUR_W-1:0] CUR_MAX   = 23'h7FFFFF;

   localparam logic signed [13:0]       TEMP_REF_MV = 14'sd1000;
   localparam logic signed [10:0]       TEMP_REF_C  = 11'sd25;
   localparam logic [25:0]              DIV6_MUL    = 26'd10923;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN    = -9'sd40;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 9'sd175;

   localparam logic [CUR_W-1:0]         OC_LIMIT_RST = 23'd42000;
   localparam logic signed [TEMP_W-1:0] OT_LIMIT_RST = 9'sd140;
   localparam logic [RAW_W-1:0]         OL_CUR_RST   = 16'd50;
   localparam logic [RAW_W-1:0]         OL_RAW_RST   = 16'd100;

   typedef enum logic [1:0] {
      REQ_SAMPLE     = 2'd0,
      REQ_SET_OFFSET = 2'd1,
      REQ_SET_SCALE  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OC_LIMIT   = 2'd0,
      CSR_OT_LIMIT   = 2'd1,
      CSR_OL_CURRENT = 2'd2,
      CSR_OL_RAW     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             en;
      logic             sel_scale;
      logic [CH_W-1:0]  ch;
      logic [TBL_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic [TBL_W-1:0] offset;
      logic [TBL_W-1:0] scale;
   } tbl_rd_type;

endpackage

/* hw/rtl/lssc_tables.sv */
// Per-channel offset and scale memories with valid bits for their reset values.
// Depends on lssc_pkg.

module lssc_tables #(
   parameter int unsigned CHANNELS = lssc_pkg::CHANNELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [lssc_pkg::CH_W-1:0] rd_ch,
   input  lssc_pkg::tbl_wr_type      wr,
   output lssc_pkg::tbl_rd_type      rd
);
   import lssc_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W = CH_W + IDX_W;

   logic [TBL_W-1:0]    off_mem [CHANNELS];
   logic [TBL_W-1:0]    sc_mem  [CHANNELS];
   logic [CHANNELS-1:0] off_vld_ff, off_vld_in;
   logic [CHANNELS-1:0] sc_vld_ff, sc_vld_in;
   logic [TBL_W-1:0]    off_rd_ff, sc_rd_ff;
   logic                off_ok_ff, off_ok_in;
   logic                sc_ok_ff, sc_ok_in;
   logic [EXT_W-1:0]    wr_ext, rd_ext;
   logic [IDX_W-1:0]    wr_idx, rd_idx;
   logic                wr_hit, rd_hit;

   assign wr_ext = EXT_W'(wr.ch);
   assign rd_ext = EXT_W'(rd_ch);
   assign wr_idx = wr_ext[IDX_W-1:0];
   assign rd_idx = rd_ext[IDX_W-1:0];
   assign wr_hit = wr.en && (wr_ext < EXT_W'(CHANNELS));
   assign rd_hit = rd_ext < EXT_W'(CHANNELS);

   always_comb begin
      off_vld_in = off_vld_ff;
      sc_vld_in  = sc_vld_ff;
      if (wr_hit) begin
         if (wr.sel_scale) begin
            sc_vld_in[wr_idx] = 1'b1;
         end else begin
            off_vld_in[wr_idx] = 1'b1;
         end
      end
      off_ok_in = rd_hit && off_vld_ff[rd_idx];
      sc_ok_in  = rd_hit && sc_vld_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_vld_ff <= '0;
         sc_vld_ff  <= '0;
      end else begin
         off_vld_ff <= off_vld_in;
         sc_vld_ff  <= sc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         if (wr.sel_scale) begin
            sc_mem[wr_idx] <= wr.data;
         end else begin
            off_mem[wr_idx] <= wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         off_ok_ff <= off_ok_in;
         sc_ok_ff  <= sc_ok_in;
         if (rd_hit) begin
            off_rd_ff <= off_mem[rd_idx];
            sc_rd_ff  <= sc_mem[rd_idx];
         end
      end
   end

   assign rd.offset = off_ok_ff ? off_rd_ff : '0;
   assign rd.scale  = sc_ok_ff ? sc_rd_ff : SCALE_ONE;

endmodule

/* hw/rtl/load_switch_sense_converter_unit.sv */
// Top level of the load switch sense converter: eight-stage conversion pipeline,
// limit registers and flag logic. Depends on lssc_pkg and lssc_tables.
//
//   Port group   Direction   Word
//   req_*        in          set offset, set scale or sample for one channel
//   rsp_*        out         converted current, temperature and flags
//   csr_*        in          limit register writes
//
// A sample word raises rsp_tvalid once it has passed the eight register stages of the
// current path (reading, microvolt split, microvolts, reciprocal estimate, back product,
// correction, scale product, saturated output) and leaves when rsp_tready is high.
// One word is accepted every cycle while req_tready is high; set words give no result.
// Each stage holds its word while the next one cannot take it, so a stall on rsp fills
// empty stages before req_tready drops. Reset clears all stage valid bits and
// the table valid bits and returns the limit registers to their defaults.

module load_switch_sense_converter_unit #(
   parameter int unsigned CHANNELS            = lssc_pkg::CHANNELS_DEF,
   parameter int unsigned SENSE_CURRENT_RATIO = lssc_pkg::SENSE_RATIO_DEF,
   parameter int unsigned SENSE_RESISTOR_OHM  = lssc_pkg::SENSE_OHM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // channel, sense_count, status_count, write_value, zero padding
   input  logic [lssc_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_channel, load_ma, temp_deg, over_current, over_temperature, open_load
   output logic [lssc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [lssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lssc_pkg::CSR_W-1:0]      csr_wdata
);
   import lssc_pkg::*;

   localparam int NS = 8;
   localparam longint unsigned DIV    = longint'(SENSE_RESISTOR_OHM) * 1000;
   localparam longint unsigned RECIP  = (longint'(SENSE_CURRENT_RATIO) << UV_W) / DIV;
   localparam longint unsigned N_MAX  = UV_MAX * SENSE_CURRENT_RATIO;
   localparam longint unsigned MA_MAX = N_MAX / DIV;
   localparam int MA_W    = (MA_MAX > 0) ? $clog2(MA_MAX + 1) : 1;
   localparam int RECIP_W = (RECIP > 0) ? $clog2(RECIP + 1) : 1;
   localparam int N_W     = $clog2(N_MAX + 1);
   localparam int D_W     = $clog2(DIV + 1);
   localparam int CMP_W   = ((N_W > D_W) ? N_W : D_W) + 1;
   localparam int PM_W    = UV_W + RECIP_W;
   localparam int PR_W    = MA_W + TBL_W;
   localparam int SAT_W   = (PR_W > CUR_W + 1) ? PR_W : CUR_W + 1;

   // Handshake and stage control
   logic [NS:1] v_ff, v_in;
   logic [NS:1] stg_rdy;
   logic        req_acc;

   logic [CH_W-1:0]  req_ch;
   logic [RAW_W-1:0] req_craw, req_sraw, req_wval;

   // Limit registers
   logic [CUR_W-1:0]         oc_limit_ff;
   logic signed [TEMP_W-1:0] ot_limit_ff;
   logic [RAW_W-1:0]         ol_cur_ff, ol_raw_ff;

   tbl_wr_type tbl_wr;
   tbl_rd_type tbl_rd;

   // Side fields carried along the pipeline
   logic [CH_W-1:0]          ch_ff    [1:NS];
   logic [TBL_W-1:0]         sc_ff    [2:6];
   logic                     olraw_ff [2:7];
   logic signed [TEMP_W-1:0] temp_ff  [4:7];

   // Stage 1
   logic [RAW_W-1:0] s1_craw_ff, s1_sraw_ff;
   logic [RAW_W-1:0] corr;
   logic [11:0]      mv_a;
   logic [16:0]      mv_s;
   logic [31:0]      s2_frac_ff, s2_frac_in;
   logic [UV_W-1:0]  s2_whole_ff, s2_whole_in;
   logic [MV_W-1:0]  s2_mv_ff, s2_mv_in;
   logic             olraw_in;

   // Stage 2
   logic [16:0]        uv_s;
   logic [15:0]        uv_q;
   logic signed [13:0] tdiff;
   logic [11:0]        tmag;
   logic [25:0]        tprod;
   logic [UV_W-1:0]    s3_uv_ff, s3_uv_in;
   logic [9:0]         s3_tq_ff, s3_tq_in;
   logic               s3_tneg_ff, s3_tneg_in;

   // Stage 3
   logic [PM_W-1:0]          recip_prod;
   logic signed [10:0]       tsum;
   logic signed [TEMP_W-1:0] temp_in;
   logic [MA_W-1:0]          s4_q0_ff, s4_q0_in;
   logic [CMP_W-1:0]         s4_n_ff, s4_n_in;

   // Stage 4
   logic [MA_W-1:0]  s5_q0_ff;
   logic [CMP_W-1:0] s5_n_ff, s5_p_ff, s5_p_in;

   // Stage 5
   logic [CMP_W-1:0] s5_rem;
   logic [MA_W-1:0]  s6_ma_ff, s6_ma_in;

   // Stage 6
   logic [PR_W-1:0] s7_prod_ff, s7_prod_in;

   // Stage 7 and output
   logic [SAT_W-1:0]         scaled;
   logic [CUR_W-1:0]         out_cur_ff, out_cur_in;
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic                     out_oc_ff, out_oc_in;
   logic                     out_ot_ff, out_ot_in;
   logic                     out_ol_ff, out_ol_in;

   assign req_ch   = req_tdata[4:0];
   assign req_craw = req_tdata[20:5];
   assign req_sraw = req_tdata[36:21];
   assign req_wval = req_tdata[52:37];

   always_comb begin
      stg_rdy[NS] = !v_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         stg_rdy[k] = !v_ff[k] || stg_rdy[k+1];
      end
   end

   assign req_tready = stg_rdy[1];
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      v_in = v_ff;
      if (stg_rdy[1]) begin
         v_in[1] = req_tvalid && (req_tuser == REQ_SAMPLE);
      end
      for (int k = 2; k <= NS; k++) begin
         if (stg_rdy[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_limit_ff <= OC_LIMIT_RST;
         ot_limit_ff <= OT_LIMIT_RST;
         ol_cur_ff   <= OL_CUR_RST;
         ol_raw_ff   <= OL_RAW_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OC_LIMIT: begin
               oc_limit_ff <= csr_wdata[CUR_W-1:0];
            end
            CSR_OT_LIMIT: begin
               ot_limit_ff <= csr_wdata[TEMP_W-1:0];
            end
            CSR_OL_CURRENT: begin
               ol_cur_ff <= csr_wdata[RAW_W-1:0];
            end
            CSR_OL_RAW: begin
               ol_raw_ff <= csr_wdata[RAW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tbl_wr.en        = req_acc &&
                         (req_tuser == REQ_SET_OFFSET || req_tuser == REQ_SET_SCALE);
      tbl_wr.sel_scale = req_tuser == REQ_SET_SCALE;
      tbl_wr.ch        = req_ch;
      tbl_wr.data      = req_wval;
   end

   lssc_tables #(
      .CHANNELS (CHANNELS)
   ) u_tables (
      .clock (clock),
      .reset (reset),
      .rd_en (stg_rdy[1]),
      .rd_ch (req_ch),
      .wr    (tbl_wr),
      .rd    (tbl_rd)
   );

   // Stage 1: offset correction, microvolt split, status millivolts
   always_comb begin
      corr        = (s1_craw_ff > tbl_rd.offset) ? s1_craw_ff - tbl_rd.offset : '0;
      s2_frac_in  = 32'(corr) * UV_FRAC_MUL;
      s2_whole_in = UV_W'(corr) * UV_WHOLE_MUL;
      mv_a        = s1_sraw_ff[15:4];
      mv_s        = 17'(mv_a) + 17'({s1_sraw_ff[3:0], 12'b0});
      s2_mv_in    = MV_W'(mv_a) + MV_W'(mv_s >= ADC_FULL);
      olraw_in    = s1_craw_ff < ol_raw_ff;
   end

   // Stage 2: finish division by 65535, temperature quotient by six
   always_comb begin
      uv_s       = 17'(s2_frac_ff[31:16]) + 17'(s2_frac_ff[15:0]);
      uv_q       = s2_frac_ff[31:16] + 16'(uv_s >= ADC_FULL);
      s3_uv_in   = s2_whole_ff + UV_W'(uv_q);
      tdiff      = $signed({1'b0, s2_mv_ff}) - TEMP_REF_MV;
      tmag       = tdiff[13] ? 12'(-tdiff) : 12'(tdiff);
      tprod      = 26'(tmag) * DIV6_MUL;
      s3_tq_in   = tprod[25:16];
      s3_tneg_in = tdiff[13];
   end

   // Stage 3: reciprocal estimate of milliamps, exact numerator, temperature clamp
   always_comb begin
      recip_prod = PM_W'(s3_uv_ff) * PM_W'(RECIP);
      s4_q0_in   = MA_W'(recip_prod >> UV_W);
      s4_n_in    = CMP_W'(s3_uv_ff) * CMP_W'(SENSE_CURRENT_RATIO);
      tsum       = (s3_tneg_ff ? -$signed({1'b0, s3_tq_ff}) : $signed({1'b0, s3_tq_ff}))
                   + TEMP_REF_C;
      if (tsum < TEMP_MIN) begin
         temp_in = TEMP_MIN;
      end else if (tsum > TEMP_MAX) begin
         temp_in = TEMP_MAX;
      end else begin
         temp_in = tsum[TEMP_W-1:0];
      end
   end

   // Stage 4: back-multiply the estimate
   assign s5_p_in = CMP_W'(s4_q0_ff) * CMP_W'(DIV);

   // Stage 5: the estimate is low by at most one
   always_comb begin
      s5_rem   = s5_n_ff - s5_p_ff;
      s6_ma_in = (s5_rem >= CMP_W'(DIV)) ? s5_q0_ff + MA_W'(1) : s5_q0_ff;
   end

   // Stage 6: channel scale
   assign s7_prod_in = PR_W'(s6_ma_ff) * PR_W'(sc_ff[6]);

   // Stage 7: saturation and flags
   always_comb begin
      scaled     = SAT_W'(s7_prod_ff) >> 8;
      out_cur_in = (scaled > SAT_W'(CUR_MAX)) ? CUR_MAX : CUR_W'(scaled);
      out_oc_in  = out_cur_in > oc_limit_ff;
      out_ot_in  = temp_ff[7] > ot_limit_ff;
      out_ol_in  = (out_cur_in < CUR_W'(ol_cur_ff)) && olraw_ff[7];
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         ch_ff[1]   <= req_ch;
         s1_craw_ff <= req_craw;
         s1_sraw_ff <= req_sraw;
      end
      for (int k = 2; k <= NS; k++) begin
         if (stg_rdy[k]) begin
            ch_ff[k] <= ch_ff[k-1];
         end
      end
      if (stg_rdy[2]) begin
         sc_ff[2]    <= tbl_rd.scale;
         olraw_ff[2] <= olraw_in;
         s2_frac_ff  <= s2_frac_in;
         s2_whole_ff <= s2_whole_in;
         s2_mv_ff    <= s2_mv_in;
      end
      for (int k = 3; k <= 6; k++) begin
         if (stg_rdy[k]) begin
            sc_ff[k] <= sc_ff[k-1];
         end
      end
      for (int k = 3; k <= 7; k++) begin
         if (stg_rdy[k]) begin
            olraw_ff[k] <= olraw_ff[k-1];
         end
      end
      if (stg_rdy[3]) begin
         s3_uv_ff   <= s3_uv_in;
         s3_tq_ff   <= s3_tq_in;
         s3_tneg_ff <= s3_tneg_in;
      end
      if (stg_rdy[4]) begin
         temp_ff[4] <= temp_in;
         s4_q0_ff   <= s4_q0_in;
         s4_n_ff    <= s4_n_in;
      end
      for (int k = 5; k <= 7; k++) begin
         if (stg_rdy[k]) begin
            temp_ff[k] <= temp_ff[k-1];
         end
      end
      if (stg_rdy[5]) begin
         s5_q0_ff <= s4_q0_ff;
         s5_n_ff  <= s4_n_ff;
         s5_p_ff  <= s5_p_in;
      end
      if (stg_rdy[6]) begin
         s6_ma_ff <= s6_ma_in;
      end
      if (stg_rdy[7]) begin
         s7_prod_ff <= s7_prod_in;
      end
      if (stg_rdy[8]) begin
         out_cur_ff  <= out_cur_in;
         out_temp_ff <= temp_ff[7];
         out_oc_ff   <= out_oc_in;
         out_ot_ff   <= out_ot_in;
         out_ol_ff   <= out_ol_in;
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = {out_ol_ff, out_ot_ff, out_oc_ff, out_temp_ff, out_cur_ff, ch_ff[NS]};

   a_set_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser != REQ_SAMPLE) |=> !v_ff[1])
      else $error("set word entered the conversion pipeline");

   a_recip_error: assert property (@(posedge clock) disable iff (reset)
      v_ff[5] |-> (s5_n_ff >= s5_p_ff) && (s5_rem < CMP_W'(2 * DIV)))
      else $error("reciprocal estimate off by more than one");

   a_temp_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_temp_ff >= TEMP_MIN) && (out_temp_ff <= TEMP_MAX))
      else $error("temperature outside clamp range");

endmodule
